FILE: src/cwps_pkg.sv
// Package for the content warning pattern scanner: window sizes, pattern table,
// precomputed compare masks and the control struct shared by the window cells.
// No dependencies.
package cwps_pkg;

  localparam int unsigned WindowLen   = 14;
  localparam int unsigned HistLen     = WindowLen - 1;
  localparam int unsigned NumPatterns = 9;
  localparam int unsigned CountW      = 4;
  localparam int unsigned PatW        = WindowLen * 8;

  // Pattern text, right-aligned: the last pattern byte sits in bits [7:0].
  // Regex-looking entries are matched literally, backslash included.
  localparam logic [PatW-1:0] PatText [NumPatterns] = '{
    PatW'("rm -rf /"),
    PatW'("rm -rf /*"),
    PatW'("curl.*\\|.*bash"),
    PatW'("wget.*\\|.*sh"),
    PatW'("eval("),
    PatW'(":(){:|:&};:"),
    PatW'("chmod 777"),
    PatW'("mkfs"),
    PatW'("> /dev/")
  };

  localparam int unsigned PatLen [NumPatterns] = '{8, 9, 14, 12, 5, 11, 9, 4, 7};

  // Window byte j (0 = newest) takes part in the compare when j < len.
  function automatic logic [WindowLen-1:0] byte_mask(int unsigned len);
    logic [WindowLen-1:0] m;
    m = '0;
    for (int unsigned j = 0; j < WindowLen; j++) begin
      if (j < len) m[j] = 1'b1;
    end
    return m;
  endfunction

  // History cell i (HistLen-1 = newest) must hold a valid byte for a match.
  function automatic logic [HistLen-1:0] hist_mask(int unsigned len);
    logic [HistLen-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < HistLen; i++) begin
      if (i + len > HistLen) m[i] = 1'b1;
    end
    return m;
  endfunction

  // Shift/clear control handed to every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Result of one scanned text.
  typedef struct packed {
    logic [NumPatterns-1:0] hits;
    logic [CountW-1:0]      count;
  } scan_result_t;

endpackage

FILE: src/cwps_if.sv
// Stream interfaces of the pattern scanner: text input and result output.
// Depends on cwps_pkg for widths.
interface cwps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, text_byte, byte_present, end_of_text, input ready);
  modport sink   (input valid, text_byte, byte_present, end_of_text, output ready);
endinterface

interface cwps_out_if;
  logic                              valid;
  logic                              ready;
  logic [cwps_pkg::NumPatterns-1:0]  pattern_hits;
  logic [cwps_pkg::CountW-1:0]       hit_count;

  modport source (output valid, pattern_hits, hit_count, input ready);
  modport sink   (input valid, pattern_hits, hit_count, output ready);
endinterface

FILE: src/cwps_cell.sv
// One window cell: holds a folded text byte and its valid bit, takes its
// neighbor's byte on each shift. Depends on cwps_pkg.
module cwps_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cwps_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  input  logic                 valid_i,
  output logic [7:0]           byte_o,
  output logic                 valid_o
);

  logic [7:0] byte_q, byte_d;
  logic       valid_q, valid_d;

  // Clear wins over shift: the end-of-text beat scans first, then empties the window
  always_comb begin
    byte_d  = byte_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      byte_d  = '0;
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      byte_d  = byte_i;
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      byte_q  <= byte_d;
      valid_q <= valid_d;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

FILE: src/cwps_match.sv
// Parallel pattern compare over the window, sticky hit flags and hit count.
// Depends on cwps_pkg.
module cwps_match (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic [cwps_pkg::WindowLen-1:0][7:0]            win_i,
  input  logic [cwps_pkg::HistLen-1:0]                   hist_valid_i,
  input  cwps_pkg::cell_ctrl_t                           ctrl_i,
  output cwps_pkg::scan_result_t                         result_o
);

  logic [cwps_pkg::NumPatterns-1:0] flags_q, flags_d, hit;
  logic [cwps_pkg::CountW-1:0]      cnt;

  // One comparator per pattern; a pattern ends at the newest byte
  always_comb begin
    for (int unsigned k = 0; k < cwps_pkg::NumPatterns; k++) begin
      logic [cwps_pkg::WindowLen-1:0] bmask;
      logic [cwps_pkg::HistLen-1:0]   hmask;
      logic                           same;
      bmask = cwps_pkg::byte_mask(cwps_pkg::PatLen[k]);
      hmask = cwps_pkg::hist_mask(cwps_pkg::PatLen[k]);
      same  = (cwps_pkg::PatLen[k] != 0) && (cwps_pkg::PatLen[k] <= cwps_pkg::WindowLen);
      for (int unsigned j = 0; j < cwps_pkg::WindowLen; j++) begin
        if (bmask[j] && (win_i[j] != cwps_pkg::PatText[k][j*8 +: 8])) same = 1'b0;
      end
      // enough valid history bytes for this pattern
      if ((hist_valid_i & hmask) != hmask) same = 1'b0;
      hit[k] = ctrl_i.shift && same;
    end
  end

  // Flags including this beat's hits
  always_comb begin
    flags_d = flags_q | hit;
    cnt     = '0;
    for (int unsigned k = 0; k < cwps_pkg::NumPatterns; k++) begin
      cnt = cnt + cwps_pkg::CountW'(flags_d[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ctrl_i.clear) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign result_o.hits  = flags_d;
  assign result_o.count = cnt;

endmodule

FILE: src/content_warning_pattern_scanner_core.sv
// Top level of the content warning pattern scanner: window cell chain,
// pattern matcher and result register. Depends on cwps_pkg, cwps_if,
// cwps_cell and cwps_match.
//
// Usage: text enters on in_i one byte per beat (valid/ready). byte_present
// marks a real byte; end_of_text closes the text. Bytes are folded to lower
// case and shifted through a chain of 13 window cells; each beat compares the
// window ending at the new byte against nine fixed patterns in parallel and
// sets sticky hit flags. On the end-of-text beat the flags and their count are
// loaded into the output register and all state is cleared.
// Throughput: one beat per cycle while the result register is not stalled.
// A result is registered and is valid on out_o the cycle after its
// end-of-text beat. Beats without end_of_text give no result.
// Stall: the result register holds its beat until out_o.ready; while it is
// full and not taken, in_i.ready is low, otherwise input flows every cycle.
// Reset: asynchronous, active low; clears window, flags and output valid.
module content_warning_pattern_scanner_core (
  input logic         clk_i,
  input logic         rst_ni,
  cwps_in_if.sink     in_i,
  cwps_out_if.source  out_o
);

  localparam int unsigned HL = cwps_pkg::HistLen;

  logic                                 in_accept;
  logic [7:0]                           folded;
  cwps_pkg::cell_ctrl_t                 ctrl;
  logic [HL-1:0][7:0]                   hist_byte;
  logic [HL-1:0]                        hist_valid;
  logic [cwps_pkg::WindowLen-1:0][7:0]  win;
  cwps_pkg::scan_result_t               result;

  logic                                 out_valid_q, out_valid_d;
  cwps_pkg::scan_result_t               out_data_q, out_data_d;

  assign in_i.ready = out_o.ready || !out_valid_q;
  assign in_accept  = in_i.valid && in_i.ready;

  // Fold A-Z to lower case
  always_comb begin
    folded = in_i.text_byte;
    if ((in_i.text_byte >= 8'h41) && (in_i.text_byte <= 8'h5A)) begin
      folded = in_i.text_byte + 8'h20;
    end
  end

  assign ctrl.shift = in_accept && in_i.byte_present;
  assign ctrl.clear = in_accept && in_i.end_of_text;

  // Window cell chain; the last cell takes the new byte
  for (genvar i = 0; i < HL; i++) begin : g_cell
    logic [7:0] nb;
    logic       nv;
    if (i == HL - 1) begin : g_head
      assign nb = folded;
      assign nv = 1'b1;
    end else begin : g_body
      assign nb = hist_byte[i+1];
      assign nv = hist_valid[i+1];
    end
    cwps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .byte_i  (nb),
      .valid_i (nv),
      .byte_o  (hist_byte[i]),
      .valid_o (hist_valid[i])
    );
  end

  // Window seen by the matcher: index 0 is the incoming byte
  always_comb begin
    win[0] = folded;
    for (int unsigned j = 1; j < cwps_pkg::WindowLen; j++) begin
      win[j] = hist_byte[HL-j];
    end
  end

  cwps_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_i        (win),
    .hist_valid_i (hist_valid),
    .ctrl_i       (ctrl),
    .result_o     (result)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (ctrl.clear) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pattern_hits = out_data_q.hits;
  assign out_o.hit_count    = out_data_q.count;

endmodule

FILE: src/cwps_checker.sv
// Port-level assertions for the pattern scanner and the bind that attaches
// them to content_warning_pattern_scanner_core. Depends on cwps_pkg.
module cwps_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_end_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [cwps_pkg::NumPatterns-1:0] out_hits_i,
  input logic [cwps_pkg::CountW-1:0]      out_count_i
);

  // An end-of-text beat always produces a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_end_i |=> out_valid_i)
    else $error("no result after end-of-text beat");

  // Count agrees with the hit mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_count_i == $countones(out_hits_i)))
    else $error("hit_count does not match pattern_hits");

  // A held result blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted while result stalled");

  // Stalled result stays valid and stable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_hits_i)
      && $stable(out_count_i))
    else $error("stalled result changed");

endmodule

bind content_warning_pattern_scanner_core cwps_checker u_cwps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_end_i    (in_i.end_of_text),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hits_i  (out_o.pattern_hits),
  .out_count_i (out_o.hit_count)
);
